FILE: hw/rtl/ftr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftr_pkg;

  // Default screen size in pixels
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 160;

  // Configuration register indexes
  localparam logic [2:0] REG_MARGIN_X = 3'd0;
  localparam logic [2:0] REG_START_Y  = 3'd1;
  localparam logic [2:0] REG_FG_COLOR = 3'd2;
  localparam logic [2:0] REG_BG_COLOR = 3'd3;
  localparam logic [2:0] REG_SCALE    = 3'd4;

  // Character codes with special meaning
  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_FIRST     = 8'd32;
  localparam logic [7:0] CHAR_LAST      = 8'd126;

  // Glyph geometry
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_NUM  = 95;

  typedef struct packed {
    logic [7:0] char_code;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  rect_x0;
    logic [7:0]  rect_y0;
    logic [6:0]  rect_x1;
    logic [7:0]  rect_y1;
    logic [15:0] pixel_color;
    logic        last;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the input word, apply restart and control codes
    logic step;   // move to the next glyph cell
    logic take;   // capture current square into pending, push old pending
    logic flush;  // push pending as the final square
    logic adv;    // advance cursor after the glyph
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_ctrl;    // input word is line feed or carriage return
    logic hit;        // current cell gives a visible square
    logic last_cell;  // current cell is the final one of the glyph
    logic pend_v;     // a square waits in the pending register
    logic out_free;   // output register can take a word this cycle
  } dp_sts_t;

  // 5x7 font, one byte per column, bit 0 is the top row
  localparam logic [0:4][7:0] FONT_ROM [0:94] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14},'{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E},'{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30},'{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E},'{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36},'{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C},'{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01},'{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F},'{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01},'{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40},'{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F},'{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06},'{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01},'{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F},'{8'h7F,8'h20,8'h18,8'h20,8'h7F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F},'{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7E,8'h09,8'h01,8'h02},'{8'h0C,8'h52,8'h52,8'h52,8'h3E},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3D,8'h00},'{8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00},'{8'h7C,8'h04,8'h18,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7C},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3F,8'h44,8'h40,8'h20},'{8'h3C,8'h40,8'h40,8'h20,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C},'{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h08,8'h08,8'h2A,8'h1C,8'h08}
  };

  // Column byte of one glyph
  function automatic logic [7:0] glyph_col(input logic [6:0] g, input logic [2:0] c);
    glyph_col = FONT_ROM[g][c];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ftr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ftr_ctrl
  import ftr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Take a word only between glyphs
  assign in_stall = (state_r != ST_IDLE);

  // Sequence load, cell scan and final flush
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.is_ctrl) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // hold while a visible square has nowhere to go
        if (!(sts.hit && sts.pend_v && !sts.out_free)) begin
          cmd.step = 1'b1;
          cmd.take = sts.hit;
          if (sts.last_cell) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_v) begin
          cmd.adv   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          cmd.adv   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ftr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ftr_dp
  import ftr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts
);

  localparam logic signed [17:0] X_MAX = 18'(SCREEN_WIDTH - 1);
  localparam logic signed [17:0] Y_MAX = 18'(SCREEN_HEIGHT - 1);
  localparam logic signed [17:0] X_LIM = 18'(SCREEN_WIDTH);
  localparam logic [2:0] COL_END = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] ROW_END = 3'(GLYPH_ROWS - 1);

  // Configuration registers
  logic [15:0] margin_x_r, start_y_r, fg_color_r, bg_color_r;
  logic [3:0]  scale_r;

  // Cursor and scan state
  logic [15:0]        cursor_col_r, cursor_row_r;
  logic [6:0]         glyph_r;
  logic [2:0]         col_idx_r, row_idx_r;
  logic signed [17:0] x0_r, y0_r, cy_r;

  // Pending square and output word
  out_word_t pend_r;
  logic      pend_v_r;
  out_word_t out_r;
  logic      out_v_r;

  logic [15:0]        col0, row0;
  logic [6:0]         s6, s8;
  logic [15:0]        col_adv;
  logic               wrap;
  logic signed [17:0] s18, x1, y1, xc0, xc1, yc0, yc1;
  logic [7:0]         col_bits;
  logic               dot;
  logic               push;
  out_word_t          cand;
  out_word_t          push_word;
  logic [7:0]         code;

  assign code = in_data.char_code;
  assign s6   = 7'({scale_r, 2'b00}) + 7'({scale_r, 1'b0});
  assign s8   = {scale_r, 3'b000};
  assign s18  = $signed({14'b0, scale_r});

  // Cursor at the start of this word
  assign col0 = in_data.restart ? margin_x_r : cursor_col_r;
  assign row0 = in_data.restart ? start_y_r  : cursor_row_r;

  // Cursor step after a glyph and the wrap test
  assign col_adv = cursor_col_r + 16'(s6);
  assign wrap    = $signed({{2{col_adv[15]}}, col_adv}) > (X_LIM - $signed({11'b0, s6}));

  // Current cell: dot and clipped square
  assign col_bits = glyph_col(glyph_r, col_idx_r);
  assign dot      = col_bits[row_idx_r];
  assign x1  = x0_r + s18 - 18'sd1;
  assign y1  = y0_r + s18 - 18'sd1;
  assign xc0 = (x0_r < 0) ? 18'sd0 : x0_r;
  assign yc0 = (y0_r < 0) ? 18'sd0 : y0_r;
  assign xc1 = (x1 > X_MAX) ? X_MAX : x1;
  assign yc1 = (y1 > Y_MAX) ? Y_MAX : y1;

  always_comb begin
    cand.rect_x0     = xc0[6:0];
    cand.rect_y0     = yc0[7:0];
    cand.rect_x1     = xc1[6:0];
    cand.rect_y1     = yc1[7:0];
    cand.pixel_color = dot ? fg_color_r : bg_color_r;
    cand.last        = 1'b0;
  end

  // Status to the controller
  assign sts.is_ctrl   = (code == CHAR_LF) || (code == CHAR_CR);
  assign sts.hit       = (dot || (fg_color_r != bg_color_r)) && !(xc0 > xc1) && !(yc0 > yc1);
  assign sts.last_cell = (col_idx_r == COL_END) && (row_idx_r == ROW_END);
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = !out_v_r || !out_stall;

  assign push      = (cmd.take && pend_v_r) || cmd.flush;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_x_r <= '0;
      start_y_r  <= '0;
      fg_color_r <= 16'hFFFF;
      bg_color_r <= '0;
      scale_r    <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MARGIN_X: margin_x_r <= cfg_data;
        REG_START_Y:  start_y_r  <= cfg_data;
        REG_FG_COLOR: fg_color_r <= cfg_data;
        REG_BG_COLOR: bg_color_r <= cfg_data;
        REG_SCALE:    scale_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Update the cursor on load and after each glyph
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else if (cmd.load) begin
      if (code == CHAR_LF) begin
        cursor_col_r <= margin_x_r;
        cursor_row_r <= row0 + 16'(s8);
      end else if (code == CHAR_CR) begin
        cursor_col_r <= margin_x_r;
        cursor_row_r <= row0;
      end else begin
        cursor_col_r <= col0;
        cursor_row_r <= row0;
      end
    end else if (cmd.adv) begin
      if (wrap) begin
        cursor_col_r <= margin_x_r;
        cursor_row_r <= cursor_row_r + 16'(s8);
      end else begin
        cursor_col_r <= col_adv;
      end
    end
  end

  // Walk the glyph down each column, then on to the next column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_idx_r <= '0;
      row_idx_r <= '0;
    end else if (cmd.load) begin
      col_idx_r <= '0;
      row_idx_r <= '0;
    end else if (cmd.step) begin
      if (row_idx_r == ROW_END) begin
        row_idx_r <= '0;
        col_idx_r <= col_idx_r + 3'd1;
      end else begin
        row_idx_r <= row_idx_r + 3'd1;
      end
    end
  end

  // Square origin of the current cell, kept by repeated adds
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_r <= ((code < CHAR_FIRST) || (code > CHAR_LAST)) ? 7'd0 : 7'(code - CHAR_FIRST);
      x0_r    <= $signed({{2{col0[15]}}, col0});
      y0_r    <= $signed({{2{row0[15]}}, row0});
      cy_r    <= $signed({{2{row0[15]}}, row0});
    end else if (cmd.step) begin
      if (row_idx_r == ROW_END) begin
        y0_r <= cy_r;
        x0_r <= x0_r + s18;
      end else begin
        y0_r <= y0_r + s18;
      end
    end
  end

  // Keep one square back so the final one can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.take) begin
      pend_v_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_r <= cand;
    end
  end

  // Mark the pending square as final on flush
  always_comb begin
    push_word      = pend_r;
    push_word.last = cmd.flush;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= push_word;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/font_text_rectangle_renderer.sv
`timescale 1ns / 1ps
`default_nettype none

// 5x7 text renderer. Each input word carries one character byte; the block keeps a
// text cursor and turns the glyph into filled squares, one output word per visible
// square, with last set on the final square of the character. Line feed and carriage
// return move the cursor only and never hold the input. Any other code scans all
// 35 glyph cells at one cell per cycle, held while the output stalls: accept, the
// cell scan, then a flush of the held-back final square before ready again. The
// single cell scanner and one-word hold mean a new character waits for the last
// one to finish. Write configuration only while idle.
module font_text_rectangle_renderer
  import ftr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  ftr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftr_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ftr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ftr_checker
  import ftr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // A drawn character keeps the input busy
  a_glyph_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.char_code != CHAR_LF) && (in_data.char_code != CHAR_CR)
    |=> in_stall)
    else $error("input ready right after a drawn character");

  // Line feed and carriage return leave the input ready in the next cycle
  a_ctrl_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && ((in_data.char_code == CHAR_LF) || (in_data.char_code == CHAR_CR))
    |=> !in_stall)
    else $error("control code held the input");

endmodule

bind font_text_rectangle_renderer ftr_checker u_ftr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
